// ===== src/ptt_pkg.sv =====
// Shared types and constants of the periodic timer table.
`default_nettype none

package ptt_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int HANDLE_BITS_DEF = 8;
  localparam int DATA_W          = 32;
  localparam int OUT_HANDLE_W    = 8;
  localparam int USED_W          = 5;
  localparam int REQ_W           = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK       = 3'd0,
    REQ_REGISTER   = 3'd1,
    REQ_UNREGISTER = 3'd2,
    REQ_START      = 3'd3,
    REQ_STOP       = 3'd4
  } req_t;

  // Per-cell command for one cycle.
  typedef struct packed {
    logic load;
    logic rotate;
    logic compact;
    logic phase;
  } cell_ctrl_t;

  // What the head unit did with the slot passing through it.
  typedef struct packed {
    logic fire;
    logic drop;
    logic hit;
  } head_evt_t;

endpackage

`default_nettype wire

// ===== src/ptt_cell.sv =====
// One slot of the timer chain: holds a slot and trades it with its neighbours.
`default_nettype none

module ptt_cell #(
  parameter int SLOTS       = ptt_pkg::SLOTS_DEF,
  parameter int HANDLE_BITS = ptt_pkg::HANDLE_BITS_DEF,
  parameter int IDX         = 0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  ptt_pkg::cell_ctrl_t          ctrl,
  input  wire [HANDLE_BITS-1:0]        ld_handle,
  input  wire [ptt_pkg::DATA_W-1:0]    ld_period,
  input  wire                          l_valid,
  input  wire [HANDLE_BITS-1:0]        l_handle,
  input  wire [ptt_pkg::DATA_W-1:0]    l_period,
  input  wire [ptt_pkg::DATA_W-1:0]    l_count,
  input  wire                          l_active,
  input  wire                          r_valid,
  input  wire [HANDLE_BITS-1:0]        r_handle,
  input  wire [ptt_pkg::DATA_W-1:0]    r_period,
  input  wire [ptt_pkg::DATA_W-1:0]    r_count,
  input  wire                          r_active,
  output logic                         q_valid,
  output logic [HANDLE_BITS-1:0]       q_handle,
  output logic [ptt_pkg::DATA_W-1:0]   q_period,
  output logic [ptt_pkg::DATA_W-1:0]   q_count,
  output logic                         q_active
);

  localparam logic ODD   = 1'((IDX % 2) == 1);
  localparam logic HAS_L = 1'(IDX > 0);
  localparam logic HAS_R = 1'(IDX < SLOTS - 1);

  logic                       valid_r, valid_nxt;
  logic [HANDLE_BITS-1:0]     handle_r, handle_nxt;
  logic [ptt_pkg::DATA_W-1:0] period_r, period_nxt;
  logic [ptt_pkg::DATA_W-1:0] count_r, count_nxt;
  logic                       active_r, active_nxt;
  logic                       pair_left;
  logic                       take_r;
  logic                       take_l;

  // In a compaction phase the cells pair up; an empty left cell takes a
  // live right one, so live slots drift to the front in their order.
  assign pair_left = (ODD == ctrl.phase);
  assign take_r = ctrl.rotate ||
                  (ctrl.compact && HAS_R && pair_left && !valid_r && r_valid);
  assign take_l = ctrl.compact && HAS_L && !pair_left && !l_valid && valid_r;

  always_comb begin
    valid_nxt  = valid_r;
    handle_nxt = handle_r;
    period_nxt = period_r;
    count_nxt  = count_r;
    active_nxt = active_r;
    if (ctrl.load) begin
      valid_nxt  = 1'b1;
      handle_nxt = ld_handle;
      period_nxt = ld_period;
      count_nxt  = '0;
      active_nxt = 1'b0;
    end else if (take_r) begin
      valid_nxt  = r_valid;
      handle_nxt = r_handle;
      period_nxt = r_period;
      count_nxt  = r_count;
      active_nxt = r_active;
    end else if (take_l) begin
      valid_nxt  = l_valid;
      handle_nxt = l_handle;
      period_nxt = l_period;
      count_nxt  = l_count;
      active_nxt = l_active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    handle_r <= handle_nxt;
    period_r <= period_nxt;
    count_r  <= count_nxt;
    active_r <= active_nxt;
  end

  assign q_valid  = valid_r;
  assign q_handle = handle_r;
  assign q_period = period_r;
  assign q_count  = count_r;
  assign q_active = active_r;

endmodule

`default_nettype wire

// ===== src/ptt_head.sv =====
// Head unit: applies the current request to the slot leaving the front of the chain.
`default_nettype none

module ptt_head #(
  parameter int HANDLE_BITS = ptt_pkg::HANDLE_BITS_DEF
) (
  input  ptt_pkg::req_t                op,
  input  wire [HANDLE_BITS-1:0]        key,
  input  wire                          found,
  input  wire                          s_valid,
  input  wire [HANDLE_BITS-1:0]        s_handle,
  input  wire [ptt_pkg::DATA_W-1:0]    s_period,
  input  wire [ptt_pkg::DATA_W-1:0]    s_count,
  input  wire                          s_active,
  output logic                         o_valid,
  output logic [HANDLE_BITS-1:0]       o_handle,
  output logic [ptt_pkg::DATA_W-1:0]   o_period,
  output logic [ptt_pkg::DATA_W-1:0]   o_count,
  output logic                         o_active,
  output ptt_pkg::head_evt_t           evt
);

  logic [ptt_pkg::DATA_W-1:0] count_inc;
  logic                       key_match;

  assign count_inc = s_count + ptt_pkg::DATA_W'(1);
  assign key_match = s_valid && (s_handle == key);

  always_comb begin
    o_valid  = s_valid;
    o_handle = s_handle;
    o_period = s_period;
    o_count  = s_count;
    o_active = s_active;
    evt      = '0;
    unique case (op)
      ptt_pkg::REQ_TICK: begin
        if (s_valid && s_active) begin
          if (count_inc >= s_period) begin
            o_count  = '0;
            // A null handle expires silently.
            evt.fire = (s_handle != '0);
          end else begin
            o_count = count_inc;
          end
        end
      end
      ptt_pkg::REQ_UNREGISTER: begin
        if (key_match) begin
          o_valid  = 1'b0;
          evt.drop = 1'b1;
        end
      end
      ptt_pkg::REQ_START, ptt_pkg::REQ_STOP: begin
        if (key_match && !found) begin
          o_active = (op == ptt_pkg::REQ_START);
          evt.hit  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/periodic_timer_table.sv =====
// Periodic timer table: a rotating chain of timer slots with one head unit.
//
// Requests enter on in_valid/in_stall and results leave on out_valid/out_stall;
// a transfer happens on a clock edge with valid high and stall low.
// in_stall is high whenever a request is in progress, so one request is
// worked at a time. Every request gives one result, except a tick, which
// gives one result per firing slot (or a single result when none fires);
// out_last marks the final result of a request.
// Register and unknown requests go straight to the finish state; tick, start
// and stop rotate the whole chain once through the head unit, one slot per
// cycle unless a tick pauses, and unregister follows its rotation with
// odd/even compaction of the live slots toward the front.
// The result register holds one result for the receiver: while out_stall is
// high a finished result waits there, the next request holds in its final
// state (with in_stall high) until that register is free, and a tick pauses
// its rotation when a second firing slot meets a result register still held.
// Reset (rst_n low, synchronous) empties the table and drops any result.
`default_nettype none

module periodic_timer_table #(
  parameter int SLOTS       = ptt_pkg::SLOTS_DEF,
  parameter int HANDLE_BITS = ptt_pkg::HANDLE_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire [ptt_pkg::REQ_W-1:0]          in_req_type,
  input  wire [HANDLE_BITS-1:0]             in_handle,
  input  wire [ptt_pkg::DATA_W-1:0]         in_period,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              out_fired,
  output logic [ptt_pkg::OUT_HANDLE_W-1:0]  out_fired_handle,
  output logic                              out_status,
  output logic [ptt_pkg::USED_W-1:0]        out_used_slots,
  output logic                              out_last
);

  localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_COMPACT,
    S_FINISH
  } state_t;

  state_t                            state_r, state_nxt;
  ptt_pkg::req_t                     op_r, op_nxt;
  logic [HANDLE_BITS-1:0]            key_r, key_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [TOT_W-1:0]                  total_r, total_nxt;
  logic                              found_r, found_nxt;
  logic                              status_r, status_nxt;
  logic                              pend_valid_r, pend_valid_nxt;
  logic [ptt_pkg::OUT_HANDLE_W-1:0]  pend_handle_r, pend_handle_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_fired_r, out_fired_nxt;
  logic [ptt_pkg::OUT_HANDLE_W-1:0]  out_fhandle_r, out_fhandle_nxt;
  logic                              out_status_r, out_status_nxt;
  logic [ptt_pkg::USED_W-1:0]        out_used_r, out_used_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              accept;
  logic                              out_free;
  logic                              step;
  logic                              cnt_last;
  logic                              do_load;

  ptt_pkg::cell_ctrl_t               ctrl [SLOTS];

  logic                              c_valid  [SLOTS];
  logic [HANDLE_BITS-1:0]            c_handle [SLOTS];
  logic [ptt_pkg::DATA_W-1:0]        c_period [SLOTS];
  logic [ptt_pkg::DATA_W-1:0]        c_count  [SLOTS];
  logic                              c_active [SLOTS];

  logic                              h_valid;
  logic [HANDLE_BITS-1:0]            h_handle;
  logic [ptt_pkg::DATA_W-1:0]        h_period;
  logic [ptt_pkg::DATA_W-1:0]        h_count;
  logic                              h_active;
  ptt_pkg::head_evt_t                evt;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_last = (cnt_r == CNT_W'(SLOTS - 1));
  // A second firing slot needs the result register for the one before it.
  assign step     = !(evt.fire && pend_valid_r && !out_free);
  assign do_load  = accept && (in_req_type == ptt_pkg::REQ_REGISTER) &&
                    (total_r < TOT_W'(SLOTS));

  ptt_head #(
    .HANDLE_BITS (HANDLE_BITS)
  ) u_head (
    .op       (op_r),
    .key      (key_r),
    .found    (found_r),
    .s_valid  (c_valid[0]),
    .s_handle (c_handle[0]),
    .s_period (c_period[0]),
    .s_count  (c_count[0]),
    .s_active (c_active[0]),
    .o_valid  (h_valid),
    .o_handle (h_handle),
    .o_period (h_period),
    .o_count  (h_count),
    .o_active (h_active),
    .evt      (evt)
  );

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      ctrl[k].load    = do_load && (total_r == TOT_W'(k));
      ctrl[k].rotate  = (state_r == S_WALK) && step;
      ctrl[k].compact = (state_r == S_COMPACT);
      ctrl[k].phase   = cnt_r[0];
    end
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    logic                       lv, rv;
    logic [HANDLE_BITS-1:0]     lh, rh;
    logic [ptt_pkg::DATA_W-1:0] lp, rp, lc, rc;
    logic                       la, ra;

    if (k == 0) begin : g_first
      assign lv = 1'b0;
      assign lh = '0;
      assign lp = '0;
      assign lc = '0;
      assign la = 1'b0;
    end else begin : g_mid
      assign lv = c_valid[k-1];
      assign lh = c_handle[k-1];
      assign lp = c_period[k-1];
      assign lc = c_count[k-1];
      assign la = c_active[k-1];
    end

    // The last cell closes the ring through the head unit.
    if (k == SLOTS - 1) begin : g_last
      assign rv = h_valid;
      assign rh = h_handle;
      assign rp = h_period;
      assign rc = h_count;
      assign ra = h_active;
    end else begin : g_inner
      assign rv = c_valid[k+1];
      assign rh = c_handle[k+1];
      assign rp = c_period[k+1];
      assign rc = c_count[k+1];
      assign ra = c_active[k+1];
    end

    ptt_cell #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS),
      .IDX         (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[k]),
      .ld_handle (in_handle),
      .ld_period (in_period),
      .l_valid   (lv),
      .l_handle  (lh),
      .l_period  (lp),
      .l_count   (lc),
      .l_active  (la),
      .r_valid   (rv),
      .r_handle  (rh),
      .r_period  (rp),
      .r_count   (rc),
      .r_active  (ra),
      .q_valid   (c_valid[k]),
      .q_handle  (c_handle[k]),
      .q_period  (c_period[k]),
      .q_count   (c_count[k]),
      .q_active  (c_active[k])
    );
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    cnt_nxt         = cnt_r;
    total_nxt       = total_r;
    found_nxt       = found_r;
    status_nxt      = status_r;
    pend_valid_nxt  = pend_valid_r;
    pend_handle_nxt = pend_handle_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_fired_nxt   = out_fired_r;
    out_fhandle_nxt = out_fhandle_r;
    out_status_nxt  = out_status_r;
    out_used_nxt    = out_used_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt        = in_handle;
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          status_nxt     = 1'b0;
          pend_valid_nxt = 1'b0;
          op_nxt         = ptt_pkg::REQ_TICK;
          case (in_req_type)
            ptt_pkg::REQ_TICK: begin
              state_nxt = S_WALK;
            end
            ptt_pkg::REQ_REGISTER: begin
              if (do_load) begin
                total_nxt = total_r + TOT_W'(1);
              end else begin
                status_nxt = 1'b1;
              end
              state_nxt = S_FINISH;
            end
            ptt_pkg::REQ_UNREGISTER: begin
              op_nxt    = ptt_pkg::REQ_UNREGISTER;
              state_nxt = S_WALK;
            end
            ptt_pkg::REQ_START: begin
              op_nxt    = ptt_pkg::REQ_START;
              state_nxt = S_WALK;
            end
            ptt_pkg::REQ_STOP: begin
              op_nxt    = ptt_pkg::REQ_STOP;
              state_nxt = S_WALK;
            end
            default: begin
              status_nxt = 1'b1;
              state_nxt  = S_FINISH;
            end
          endcase
        end
      end
      S_WALK: begin
        if (step) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (evt.fire) begin
            if (pend_valid_r) begin
              out_valid_nxt   = 1'b1;
              out_fired_nxt   = 1'b1;
              out_fhandle_nxt = pend_handle_r;
              out_status_nxt  = 1'b0;
              out_used_nxt    = ptt_pkg::USED_W'(total_r);
              out_last_nxt    = 1'b0;
            end
            pend_valid_nxt  = 1'b1;
            pend_handle_nxt = ptt_pkg::OUT_HANDLE_W'(c_handle[0]);
          end
          if (evt.drop) begin
            total_nxt = total_nxt - TOT_W'(1);
          end
          if (evt.hit) begin
            found_nxt = 1'b1;
          end
          if (cnt_last) begin
            cnt_nxt = '0;
            if (op_r == ptt_pkg::REQ_START || op_r == ptt_pkg::REQ_STOP) begin
              status_nxt = !(found_r || evt.hit);
            end
            state_nxt = (op_r == ptt_pkg::REQ_UNREGISTER) ? S_COMPACT : S_FINISH;
          end
        end
      end
      S_COMPACT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_fired_nxt   = pend_valid_r;
          out_fhandle_nxt = pend_valid_r ? pend_handle_r : '0;
          out_status_nxt  = status_r;
          out_used_nxt    = ptt_pkg::USED_W'(total_r);
          out_last_nxt    = 1'b1;
          pend_valid_nxt  = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    cnt_r         <= cnt_nxt;
    found_r       <= found_nxt;
    status_r      <= status_nxt;
    pend_handle_r <= pend_handle_nxt;
    out_fired_r   <= out_fired_nxt;
    out_fhandle_r <= out_fhandle_nxt;
    out_status_r  <= out_status_nxt;
    out_used_r    <= out_used_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_fired        = out_fired_r;
  assign out_fired_handle = out_fhandle_r;
  assign out_status       = out_status_r;
  assign out_used_slots   = out_used_r;
  assign out_last         = out_last_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_W'(SLOTS))
    else $error("slot count exceeds the table size");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_valid_r)
    else $error("a fire result is still pending while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("block took no notice of an accepted transfer");

  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (out_valid_r && out_last_r))
    else $error("request finished without a final result");

  for (genvar k = 0; k < SLOTS; k++) begin : g_chk
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_IDLE) |-> (c_valid[k] == (TOT_W'(k) < total_r)))
      else $error("live slots are not packed at the front of the chain");
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_periodic_timer_table.sv =====
// Self-checking testbench for the periodic timer table: directed rows, random requests, slot-table predictor.
`timescale 1ns / 100ps

module tb_periodic_timer_table;
  import ptt_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int HW           = HANDLE_BITS_DEF;
  localparam int RANDOM_ITEMS = 225;
  localparam int HOLD_CYCLES  = 200;
  localparam int BURST_ITEMS  = 24;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 4;

  // Request codes the block does not define; it must refuse them.
  localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

  typedef struct packed {
    logic              fired;
    logic [7:0]        fired_handle;
    logic              status;
    logic [USED_W-1:0] used_slots;
    logic              last;
  } timer_result_t;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [HW-1:0]    handle;
    logic [31:0]      period;
    int               reps;
    bit               typed;
    timer_result_t    want;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [REQ_W-1:0]        in_req_type;
  logic [HW-1:0]           in_handle;
  logic [DATA_W-1:0]       in_period;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_fired;
  logic [OUT_HANDLE_W-1:0] out_fired_handle;
  logic                    out_status;
  logic [USED_W-1:0]       out_used_slots;
  logic                    out_last;

  // Predicted slot table.
  logic [HW-1:0] tt_handle [SLOTS];
  logic [31:0]   tt_period [SLOTS];
  logic [31:0]   tt_count  [SLOTS];
  bit            tt_active [SLOTS];
  int            tt_used;

  timer_result_t due_results[$];
  timer_result_t new_results[$];
  stim_row_t     directed_rows[$];
  timer_result_t got_result;
  timer_result_t want_result;

  int  n_items;
  int  n_results;
  int  n_fired;
  int  n_refused;
  int  n_errors;
  int  idle_cycles;
  bit  calm;
  bit  hold_off_req;
  int  burst_left;

  periodic_timer_table DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_handle       (in_handle),
    .in_period       (in_period),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fired       (out_fired),
    .out_fired_handle(out_fired_handle),
    .out_status      (out_status),
    .out_used_slots  (out_used_slots),
    .out_last        (out_last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances the predicted table by one request and leaves its results in new_results.
  function automatic void apply_request(logic [REQ_W-1:0] req, logic [HW-1:0] h,
                                        logic [31:0] per);
    int            i;
    int            w;
    logic          fail;
    timer_result_t r;
    new_results.delete();
    fail = 1'b0;
    case (req)
      REQ_TICK: begin
        for (i = 0; i < tt_used; i++) begin
          if (tt_active[i]) begin
            tt_count[i] = tt_count[i] + 32'd1;
            if (tt_count[i] >= tt_period[i]) begin
              tt_count[i] = '0;
              if (tt_handle[i] != '0) begin
                r = '0;
                r.fired = 1'b1;
                r.fired_handle = tt_handle[i];
                new_results.push_back(r);
              end
            end
          end
        end
      end
      REQ_REGISTER: begin
        if (tt_used < SLOTS) begin
          tt_handle[tt_used] = h;
          tt_period[tt_used] = per;
          tt_count[tt_used]  = '0;
          tt_active[tt_used] = 1'b0;
          tt_used++;
        end else begin
          fail = 1'b1;
        end
      end
      REQ_UNREGISTER: begin
        w = 0;
        for (i = 0; i < tt_used; i++) begin
          if (tt_handle[i] != h) begin
            tt_handle[w] = tt_handle[i];
            tt_period[w] = tt_period[i];
            tt_count[w]  = tt_count[i];
            tt_active[w] = tt_active[i];
            w++;
          end
        end
        for (i = w; i < SLOTS; i++) begin
          tt_handle[i] = '0;
          tt_period[i] = '0;
          tt_count[i]  = '0;
          tt_active[i] = 1'b0;
        end
        tt_used = w;
      end
      REQ_START, REQ_STOP: begin
        fail = 1'b1;
        for (i = 0; i < tt_used && fail; i++) begin
          if (tt_handle[i] == h) begin
            tt_active[i] = (req == REQ_START);
            fail = 1'b0;
          end
        end
      end
      default: fail = 1'b1;
    endcase
    if (new_results.size() == 0) begin
      r = '0;
      r.status = fail;
      r.last = 1'b1;
      new_results.push_back(r);
    end else begin
      new_results[new_results.size() - 1].last = 1'b1;
    end
    foreach (new_results[j]) new_results[j].used_slots = USED_W'(tt_used);
  endfunction

  function automatic void add_row(logic [REQ_W-1:0] req, logic [HW-1:0] h, logic [31:0] per,
                                  int reps, bit typed, logic st, int used);
    stim_row_t row;
    row.req = req;
    row.handle = h;
    row.period = per;
    row.reps = reps;
    row.typed = typed;
    row.want = '0;
    row.want.status = st;
    row.want.used_slots = USED_W'(used);
    row.want.last = 1'b1;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [HW-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return HW'($urandom_range(1, 6));
    return HW'($urandom_range(0, 255));
  endfunction

  // Mostly a handle that is in the table, so that start, stop and unregister hit.
  function automatic logic [HW-1:0] pick_known_handle();
    if (tt_used > 0 && $urandom_range(0, 99) < 75) return tt_handle[$urandom_range(0, tt_used - 1)];
    return pick_handle();
  endfunction

  function automatic int next_gap();
    int r;
    if (calm || burst_left > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Offers one request from a falling edge and returns at the falling edge after its transfer.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [HW-1:0] h,
                              input logic [31:0] per, input bit typed,
                              input timer_result_t want);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_handle   <= h;
    in_period   <= per;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(req, h, per);
    if (typed) begin
      due_results.push_back(want);
    end else begin
      foreach (new_results[j]) due_results.push_back(new_results[j]);
    end
    n_items++;
    @(negedge clk);
  endtask

  task automatic idle_sender();
    int g;
    g = next_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result.fired        = out_fired;
      got_result.fired_handle = out_fired_handle;
      got_result.status       = out_status;
      got_result.used_slots   = out_used_slots;
      got_result.last         = out_last;
      n_results++;
      if (out_fired) n_fired++;
      if (out_status) n_refused++;
      if (due_results.size() == 0) begin
        $display("%0t: result with none due: fired=%0d handle=%02h status=%0d used=%0d last=%0d",
                 $time, out_fired, out_fired_handle, out_status, out_used_slots, out_last);
        n_errors++;
      end else begin
        want_result = due_results.pop_front();
        if (got_result !== want_result) begin
          $display("%0t: expected fired=%0d handle=%02h status=%0d used=%0d last=%0d",
                   $time, want_result.fired, want_result.fired_handle, want_result.status,
                   want_result.used_slots, want_result.last);
          $display("%0t:   actual fired=%0d handle=%02h status=%0d used=%0d last=%0d",
                   $time, got_result.fired, got_result.fired_handle, got_result.status,
                   got_result.used_slots, got_result.last);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles without any transfer on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still due",
                 $time, IDLE_LIMIT, due_results.size());
        $display("periodic_timer_table: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random stall runs, a calm stretch and one long hold-off.
  initial begin : receiver
    int  run;
    int  r;
    bit  stalling;
    run = 0;
    stalling = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
        run = 0;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        if (run == 0) begin
          r = $urandom_range(0, 99);
          stalling = (r >= 35);
          if (r < 35) run = $urandom_range(5, 40);
          else if (r < 80) run = $urandom_range(1, 3);
          else if (r < 95) run = $urandom_range(4, 12);
          else run = $urandom_range(20, 60);
        end
        out_stall <= stalling;
        run--;
      end
    end
  end

  initial begin : sender
    logic [REQ_W-1:0] req;
    logic [HW-1:0]    h;
    logic [31:0]      per;
    int               r;
    int               rand_items;
    bit               hold_done;
    bit               pause_done;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_TICK;
    in_handle = '0;
    in_period = '0;
    tt_handle = '{default: '0};
    tt_period = '{default: '0};
    tt_count  = '{default: '0};
    tt_active = '{default: 1'b0};
    tt_used = 0;
    n_items = 0;
    n_results = 0;
    n_fired = 0;
    n_refused = 0;
    n_errors = 0;
    idle_cycles = 0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    burst_left = 0;
    rand_items = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;

    // Empty table, refusals and reserved codes first, then a full table and its draining.
    add_row(REQ_TICK,       8'h00, 32'h0,        1, 1, 1'b0, 0);
    add_row(REQ_UNREGISTER, 8'h5A, 32'h0,        1, 1, 1'b0, 0);
    add_row(REQ_START,      8'h5A, 32'h0,        1, 1, 1'b1, 0);
    add_row(REQ_STOP,       8'hA5, 32'h0,        1, 1, 1'b1, 0);
    add_row(REQ_RSVD5,      8'h00, 32'h0,        1, 1, 1'b1, 0);
    add_row(REQ_RSVD6,      8'hFF, 32'hFFFFFFFF, 1, 1, 1'b1, 0);
    add_row(REQ_RSVD7,      8'h5A, 32'h0,        1, 1, 1'b1, 0);
    add_row(REQ_REGISTER,   8'hFF, 32'h0,        1, 1, 1'b0, 1);
    add_row(REQ_REGISTER,   8'h00, 32'h0,        1, 1, 1'b0, 2);
    add_row(REQ_START,      8'hFF, 32'h0,        1, 1, 1'b0, 2);
    add_row(REQ_START,      8'h00, 32'h0,        1, 1, 1'b0, 2);
    add_row(REQ_TICK,       8'hFF, 32'hFFFFFFFF, 1, 0, 1'b0, 0);
    add_row(REQ_REGISTER,   8'h01, 32'hFFFFFFFF, 1, 1, 1'b0, 3);
    add_row(REQ_REGISTER,   8'h01, 32'h1,        1, 1, 1'b0, 4);
    add_row(REQ_START,      8'h01, 32'h0,        1, 1, 1'b0, 4);
    add_row(REQ_TICK,       8'h00, 32'h0,        1, 0, 1'b0, 0);
    add_row(REQ_STOP,       8'hFF, 32'h0,        1, 1, 1'b0, 4);
    add_row(REQ_REGISTER,   8'h80, 32'h2,       12, 0, 1'b0, 0);
    add_row(REQ_REGISTER,   8'h7F, 32'h5,        1, 1, 1'b1, SLOTS);
    add_row(REQ_START,      8'h80, 32'h0,        1, 1, 1'b0, SLOTS);
    add_row(REQ_TICK,       8'h00, 32'h0,        3, 0, 1'b0, 0);
    add_row(REQ_UNREGISTER, 8'h01, 32'h0,        1, 1, 1'b0, SLOTS - 2);
    add_row(REQ_UNREGISTER, 8'h80, 32'h0,        1, 1, 1'b0, 2);
    add_row(REQ_STOP,       8'h01, 32'h0,        1, 1, 1'b1, 2);
    add_row(REQ_UNREGISTER, 8'hFF, 32'h0,        1, 1, 1'b0, 1);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[k]) begin
      repeat (directed_rows[k].reps) begin
        send_request(directed_rows[k].req, directed_rows[k].handle, directed_rows[k].period,
                     directed_rows[k].typed, directed_rows[k].want);
        idle_sender();
      end
    end

    while (rand_items < RANDOM_ITEMS) begin
      calm = (rand_items >= 40 && rand_items < 80);
      if (!hold_done && rand_items == 150) begin
        // The receiver stops for a long stretch while requests keep coming.
        hold_done = 1'b1;
        hold_off_req = 1'b1;
        burst_left = BURST_ITEMS;
      end
      if (!pause_done && rand_items == 190) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge clk);
        @(negedge clk);
      end

      r = $urandom_range(0, 99);
      if (r < 38) req = REQ_TICK;
      else if (r < 58) req = REQ_REGISTER;
      else if (r < 68) req = REQ_UNREGISTER;
      else if (r < 84) req = REQ_START;
      else if (r < 95) req = REQ_STOP;
      else if (r < 97) req = REQ_W'($urandom_range(REQ_RSVD5, REQ_RSVD7));
      else req = REQ_TICK;
      if (req == REQ_REGISTER && tt_used >= 12 && $urandom_range(0, 2) == 0) req = REQ_UNREGISTER;

      per = $urandom;
      if (req == REQ_REGISTER) begin
        h = pick_handle();
        r = $urandom_range(0, 99);
        if (r < 60) per = $urandom_range(0, 4);
        else if (r < 85) per = $urandom_range(5, 20);
        else if (r < 95) per = $urandom;
        else per = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
      end else if (req == REQ_TICK) begin
        h = HW'($urandom_range(0, 255));
      end else begin
        h = pick_known_handle();
      end

      send_request(req, h, per, 1'b0, '0);
      if (req inside {REQ_TICK, REQ_REGISTER, REQ_UNREGISTER, REQ_START, REQ_STOP}) begin
        rand_items++;
      end
      if (burst_left > 0) burst_left--;
      idle_sender();
    end

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d requests and %0d results: %0d expiries, %0d refusals,",
             n_items, n_results, n_fired, n_refused);
    $display("a full table drained by compaction and a receiver hold-off of %0d cycles.",
             HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("periodic_timer_table: match");
    end else begin
      $display("periodic_timer_table: mismatch");
    end
    $finish;
  end

endmodule
